@@ design/erfpp_pkg.sv @@
// Shared types, widths, segment limits and coefficient tables for the erf pipeline.
// No dependencies; every other design file refers to it by scoped names.
package erfpp_pkg;

   localparam int XW     = 24;   // input sample width
   localparam int OUTW   = 22;   // result width
   localparam int INT_FB = 24;   // internal fraction bits
   localparam int ZW     = 26;   // internal magnitude, clipped at the saturation limit
   localparam int TW     = 25;   // Horner variable, signed
   localparam int AW     = 28;   // Horner accumulator, signed, |acc| < 4
   localparam int CW     = 26;   // coefficient width, signed
   localparam int WW     = 25;   // clamped magnitude, 0 .. 1.0
   localparam int RW     = 56;   // product width seen by the rounding helper

   localparam int HSTEPS   = 8;  // Horner steps, highest degree in any segment
   localparam int FRONT_ST = 2;
   localparam int BACK_ST  = 2;
   localparam int NST      = FRONT_ST + HSTEPS + BACK_ST;

   localparam logic [ZW-1:0] LIM_SAT = 26'd57042534;
   localparam logic [ZW-1:0] LIM_D1  = 26'd83886;
   localparam logic [ZW-1:0] LIM_D5  = 26'd3355443;
   localparam logic [ZW-1:0] LIM_D7  = 26'd5872025;
   localparam logic [ZW-1:0] LIM_A   = 26'd11744051;
   localparam logic [ZW-1:0] LIM_B   = 26'd20132659;
   localparam logic [ZW-1:0] LIM_C   = 26'd36909875;

   localparam logic [ZW-1:0] CEN_A = 26'd8388608;
   localparam logic [ZW-1:0] CEN_B = 26'd16777216;
   localparam logic [ZW-1:0] CEN_C = 26'd29360128;
   localparam logic [ZW-1:0] CEN_D = 26'd46137344;

   localparam logic [WW-1:0] ONE_Q = WW'(2**INT_FB);

   typedef enum logic [2:0] {
      SEG_D1,
      SEG_D5,
      SEG_D7,
      SEG_A,
      SEG_B,
      SEG_C,
      SEG_D
   } seg_type;

   typedef struct packed {
      logic                  neg;
      logic                  sat;
      seg_type               seg;
      logic [ZW-1:0]         z;
      logic signed [TW-1:0]  t;
      logic signed [AW-1:0]  acc;
   } stage_type;

   // Q24 coefficients, lowest degree first
   localparam logic signed [CW-1:0] COEF_ODD [4] = '{
      26'sd18931058, -26'sd6310354, 26'sd1893106, -26'sd450740
   };
   localparam logic signed [CW-1:0] COEF_A [6] = '{
      26'sd8732539, 26'sd14743525, -26'sd7371763, -26'sd2457255,
      26'sd3071568, 26'sd122863
   };
   localparam logic signed [CW-1:0] COEF_B [6] = '{
      26'sd14138160, 26'sd6964340, -26'sd6964340, 26'sd2321450,
      26'sd1160725, -26'sd1160725
   };
   localparam logic signed [CW-1:0] COEF_C [9] = '{
      26'sd16553604, 26'sd885418, -26'sd1549481, 26'sd1512588,
      -26'sd807021, 26'sd111138, 26'sd150375, -26'sd101649, 26'sd12248
   };
   localparam logic signed [CW-1:0] COEF_D [8] = '{
      26'sd16775528, 26'sd9836, -26'sd27049, 26'sd46312,
      -26'sd54662, 26'sd46235, -26'sd27805, 26'sd10839
   };

   // Coefficient of degree k; zero above the segment's degree, so a short
   // polynomial runs through the full Horner chain unchanged.
   function automatic logic signed [CW-1:0] coef(input seg_type seg, input logic [3:0] k);
      logic signed [CW-1:0] c;
      c = '0;
      unique case (seg)
         SEG_D1: c = (k == 4'd1) ? COEF_ODD[0] : '0;
         SEG_D5: c = (k <= 4'd2) ? COEF_ODD[k[1:0]] : '0;
         SEG_D7: c = (k <= 4'd3) ? COEF_ODD[k[1:0]] : '0;
         SEG_A:  c = (k <= 4'd5) ? COEF_A[k[2:0]] : '0;
         SEG_B:  c = (k <= 4'd5) ? COEF_B[k[2:0]] : '0;
         SEG_C:  c = (k <= 4'd8) ? COEF_C[k] : '0;
         SEG_D:  c = (k <= 4'd7) ? COEF_D[k[2:0]] : '0;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Product with 48 fraction bits back to 24, nearest, ties away from zero
   function automatic logic signed [RW-1:0] round_q(input logic signed [RW-1:0] p);
      logic signed [RW-1:0] bias;
      bias = p[RW-1] ? RW'(2**(INT_FB-1) - 1) : RW'(2**(INT_FB-1));
      return (p + bias) >>> INT_FB;
   endfunction

endpackage

@@ design/erfpp_front.sv @@
// Front of the erf pipeline: magnitude, saturation, segment choice, then the
// Horner variable and the leading coefficient. Two register stages. Uses erfpp_pkg.
module erfpp_front #(
   parameter int IN_FRAC_BITS = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [erfpp_pkg::FRONT_ST-1:0]     load,
   input  logic                               vld_in,
   input  logic signed [erfpp_pkg::XW-1:0]    x_value,
   output logic [erfpp_pkg::FRONT_ST-1:0]     vld_out,
   output erfpp_pkg::stage_type               stage_out
);

   localparam int XW  = erfpp_pkg::XW;
   localparam int ZW  = erfpp_pkg::ZW;
   localparam int SHI = erfpp_pkg::INT_FB - IN_FRAC_BITS;
   localparam int SHL = (SHI > 0) ? SHI : 0;
   localparam int ZFW = XW + SHL + 2;
   localparam logic [2*ZW-1:0] SQ_HALF = (2*ZW)'(2**(erfpp_pkg::INT_FB-1));

   logic [XW-1:0]          xu;
   logic [XW-1:0]          mag;
   logic [ZFW-1:0]         zf;
   logic                   sat;
   logic [ZW-1:0]          z;
   logic [2*ZW-1:0]        sq;
   logic [2*ZW-1:0]        sq_r;
   logic [ZW-1:0]          cen;
   logic signed [ZW:0]     zdiff;

   erfpp_pkg::stage_type   mag_in, mag_ff, prep_in, prep_ff;
   logic                   mag_vld_ff, prep_vld_ff;

   assign xu  = $unsigned(x_value);
   assign mag = xu[XW-1] ? (~xu + 1'b1) : xu;

   if (SHI >= 0) begin : g_up
      assign zf = ZFW'(mag) << SHL;
   end else begin : g_down
      localparam int SR = -SHI;
      assign zf = ZFW'(({1'b0, mag} + ((XW+1)'(1) << (SR - 1))) >> SR);
   end

   assign sat = zf > ZFW'(erfpp_pkg::LIM_SAT);
   // pin saturated samples to the last segment so the Horner chain stays in range
   assign z   = sat ? erfpp_pkg::LIM_SAT : zf[ZW-1:0];

   always_comb begin
      mag_in     = '0;
      mag_in.neg = xu[XW-1];
      mag_in.sat = sat;
      mag_in.z   = z;
      priority if (z <= erfpp_pkg::LIM_D1) begin
         mag_in.seg = erfpp_pkg::SEG_D1;
      end else if (z <= erfpp_pkg::LIM_D5) begin
         mag_in.seg = erfpp_pkg::SEG_D5;
      end else if (z <= erfpp_pkg::LIM_D7) begin
         mag_in.seg = erfpp_pkg::SEG_D7;
      end else if (z <= erfpp_pkg::LIM_A) begin
         mag_in.seg = erfpp_pkg::SEG_A;
      end else if (z <= erfpp_pkg::LIM_B) begin
         mag_in.seg = erfpp_pkg::SEG_B;
      end else if (z <= erfpp_pkg::LIM_C) begin
         mag_in.seg = erfpp_pkg::SEG_C;
      end else begin
         mag_in.seg = erfpp_pkg::SEG_D;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_vld_ff <= 1'b0;
      end else if (load[0]) begin
         mag_vld_ff <= vld_in;
      end
      if (load[0]) begin
         mag_ff <= mag_in;
      end
   end

   // SEG_D5 and SEG_D7 run Horner on z*z, SEG_D1 on z, the rest on the offset from the center
   always_comb begin
      sq   = mag_ff.z * mag_ff.z;
      sq_r = (sq + SQ_HALF) >> erfpp_pkg::INT_FB;
      unique case (mag_ff.seg)
         erfpp_pkg::SEG_A: cen = erfpp_pkg::CEN_A;
         erfpp_pkg::SEG_B: cen = erfpp_pkg::CEN_B;
         erfpp_pkg::SEG_C: cen = erfpp_pkg::CEN_C;
         default:          cen = erfpp_pkg::CEN_D;
      endcase
      zdiff = $signed({1'b0, mag_ff.z}) - $signed({1'b0, cen});

      prep_in     = mag_ff;
      prep_in.acc = erfpp_pkg::AW'(erfpp_pkg::coef(mag_ff.seg, 4'd8));
      unique case (mag_ff.seg)
         erfpp_pkg::SEG_D1: prep_in.t = $signed(mag_ff.z[erfpp_pkg::TW-1:0]);
         erfpp_pkg::SEG_D5,
         erfpp_pkg::SEG_D7: prep_in.t = $signed(sq_r[erfpp_pkg::TW-1:0]);
         default:           prep_in.t = zdiff[erfpp_pkg::TW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff <= 1'b0;
      end else if (load[1]) begin
         prep_vld_ff <= mag_vld_ff;
      end
      if (load[1]) begin
         prep_ff <= prep_in;
      end
   end

   assign vld_out   = {prep_vld_ff, mag_vld_ff};
   assign stage_out = prep_ff;

endmodule

@@ design/erfpp_horner_step.sv @@
// One registered Horner step: acc = round(acc * t) + coefficient of degree K.
// Uses erfpp_pkg for the stage struct, coefficient table and rounding.
module erfpp_horner_step #(
   parameter int K = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  vld_in,
   input  erfpp_pkg::stage_type  stage_in,
   output logic                  vld_out,
   output erfpp_pkg::stage_type  stage_out
);

   localparam int AW = erfpp_pkg::AW;
   localparam int TW = erfpp_pkg::TW;
   localparam int RW = erfpp_pkg::RW;

   logic signed [AW+TW-1:0]  prod;
   logic signed [RW-1:0]     prod_r;
   erfpp_pkg::stage_type     step_in, step_ff;
   logic                     vld_ff;

   always_comb begin
      prod        = stage_in.acc * stage_in.t;
      prod_r      = erfpp_pkg::round_q(RW'(prod));
      step_in     = stage_in;
      step_in.acc = prod_r[AW-1:0] + AW'(erfpp_pkg::coef(stage_in.seg, 4'(K)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (load) begin
         vld_ff <= vld_in;
      end
      if (load) begin
         step_ff <= step_in;
      end
   end

   assign vld_out   = vld_ff;
   assign stage_out = step_ff;

`ifndef SYNTHESIS
   // accumulator keeps one bit of headroom: |acc| < 4.0
   a_acc_headroom: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (step_ff.acc[AW-1] == step_ff.acc[AW-2]))
      else $error("Horner accumulator out of range");
`endif

endmodule

@@ design/erfpp_back.sv @@
// Back of the erf pipeline: final multiply by z for the odd series, clamp to
// [0, 1], then output scaling, saturation and sign. Two register stages. Uses erfpp_pkg.
module erfpp_back #(
   parameter int OUT_FRAC_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [erfpp_pkg::BACK_ST-1:0]       load,
   input  logic                                vld_in,
   input  erfpp_pkg::stage_type                stage_in,
   output logic [erfpp_pkg::BACK_ST-1:0]       vld_out,
   output logic signed [erfpp_pkg::OUTW-1:0]   erf_value
);

   localparam int AW   = erfpp_pkg::AW;
   localparam int ZW   = erfpp_pkg::ZW;
   localparam int RW   = erfpp_pkg::RW;
   localparam int WW   = erfpp_pkg::WW;
   localparam int OUTW = erfpp_pkg::OUTW;
   localparam int SH   = OUT_FRAC_BITS - erfpp_pkg::INT_FB;
   localparam int SHL  = (SH > 0) ? SH : 0;
   localparam int RSW  = WW + SHL + 1;
   localparam logic [OUTW-1:0] MAG_MAX = OUTW'(2**(OUTW-1) - 1);

   typedef struct packed {
      logic           neg;
      logic [WW-1:0]  w;
   } post_type;

   logic signed [AW+ZW:0]  prod;
   logic signed [RW-1:0]   prod_r;
   logic signed [AW-1:0]   wv;
   logic                   odd;
   post_type               post_in, post_ff;
   logic                   post_vld_ff;
   logic [RSW-1:0]         r;
   logic [OUTW-1:0]        rsat;
   logic [OUTW-1:0]        erf_in;
   logic [OUTW-1:0]        erf_ff;
   logic                   out_vld_ff;

   always_comb begin
      prod   = stage_in.acc * $signed({1'b0, stage_in.z});
      prod_r = erfpp_pkg::round_q(RW'(prod));
      odd    = (stage_in.seg == erfpp_pkg::SEG_D5) || (stage_in.seg == erfpp_pkg::SEG_D7);
      wv     = odd ? prod_r[AW-1:0] : stage_in.acc;
      post_in.neg = stage_in.neg;
      priority if (stage_in.sat) begin
         post_in.w = erfpp_pkg::ONE_Q;
      end else if (wv < 0) begin
         post_in.w = '0;
      end else if (wv > $signed(AW'(erfpp_pkg::ONE_Q))) begin
         post_in.w = erfpp_pkg::ONE_Q;
      end else begin
         post_in.w = wv[WW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= 1'b0;
      end else if (load[0]) begin
         post_vld_ff <= vld_in;
      end
      if (load[0]) begin
         post_ff <= post_in;
      end
   end

   if (SH >= 0) begin : g_up
      assign r = RSW'(post_ff.w) << SHL;
   end else begin : g_down
      localparam int SR = -SH;
      assign r = (RSW'(post_ff.w) + (RSW'(1) << (SR - 1))) >> SR;
   end

   assign rsat   = (r > RSW'(MAG_MAX)) ? MAG_MAX : r[OUTW-1:0];
   assign erf_in = post_ff.neg ? (~rsat + 1'b1) : rsat;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (load[1]) begin
         out_vld_ff <= post_vld_ff;
      end
      if (load[1]) begin
         erf_ff <= erf_in;
      end
   end

   assign vld_out   = {out_vld_ff, post_vld_ff};
   assign erf_value = $signed(erf_ff);

`ifndef SYNTHESIS
   // a negative argument never leaves with a positive result
   a_sign: assert property (@(posedge clock) disable iff (reset)
      load[1] && post_vld_ff && post_ff.neg |=> (erf_ff[OUTW-1] || (erf_ff == '0)))
      else $error("result sign does not follow argument");
`endif

endmodule

@@ design/erf_piecewise_polynomial.sv @@
// Top level of the erf block: front stages, eight Horner steps, back stages,
// and the per-stage ready chain. Uses erfpp_pkg, erfpp_front, erfpp_horner_step, erfpp_back.
//
//   channel   ports                             direction   payload
//   req       req_valid req_stall req_x_value   in          x, Q3.20 signed, 24 bits
//   rsp       rsp_valid rsp_stall rsp_erf_value out         erf(x), Q1.20 signed, 22 bits
//
// One beat per cycle sustained while rsp_stall is low; a beat passes the two front
// register stages, the eight Horner multiply-add steps and the two back register stages.
// Synchronous active-high reset clears all stage valid bits; payload is not reset.
// Each stage holds only while it is full and the stage after it cannot take its
// beat, so bubbles close up and req_stall rises only when all 12 stages are full.
module erf_piecewise_polynomial #(
   parameter int IN_FRAC_BITS  = 20,
   parameter int OUT_FRAC_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [erfpp_pkg::XW-1:0]     req_x_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [erfpp_pkg::OUTW-1:0]   rsp_erf_value
);

   localparam int NST    = erfpp_pkg::NST;
   localparam int HSTEPS = erfpp_pkg::HSTEPS;
   localparam int FST    = erfpp_pkg::FRONT_ST;
   localparam int BST    = erfpp_pkg::BACK_ST;
   localparam int OUTW   = erfpp_pkg::OUTW;
   localparam int OUT_MAX = (OUT_FRAC_BITS >= OUTW - 1) ? (2**(OUTW-1) - 1)
                                                         : (2**OUT_FRAC_BITS);

   logic [NST-1:0]          vld;
   logic [NST:0]            rdy;
   erfpp_pkg::stage_type    hst [HSTEPS+1];

   assign rdy[NST] = !rsp_stall;
   for (genvar i = 0; i < NST; i++) begin : g_rdy
      assign rdy[i] = !vld[i] || rdy[i+1];
   end

   assign req_stall = !rdy[0];

   erfpp_front #(
      .IN_FRAC_BITS (IN_FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .load      (rdy[FST-1:0]),
      .vld_in    (req_valid),
      .x_value   (req_x_value),
      .vld_out   (vld[FST-1:0]),
      .stage_out (hst[0])
   );

   // step j applies the coefficient of degree HSTEPS-1-j
   for (genvar j = 0; j < HSTEPS; j++) begin : g_horner
      erfpp_horner_step #(
         .K (HSTEPS - 1 - j)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .load      (rdy[FST+j]),
         .vld_in    (vld[FST+j-1]),
         .stage_in  (hst[j]),
         .vld_out   (vld[FST+j]),
         .stage_out (hst[j+1])
      );
   end

   erfpp_back #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .load      (rdy[NST-1:NST-BST]),
      .vld_in    (vld[FST+HSTEPS-1]),
      .stage_in  (hst[HSTEPS]),
      .vld_out   (vld[NST-1:NST-BST]),
      .erf_value (rsp_erf_value)
   );

   assign rsp_valid = vld[NST-1];

`ifndef SYNTHESIS
   // an accepted beat is in the first stage on the next cycle
   a_entry: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld[0])
      else $error("accepted beat missing from first stage");

   // a full stage facing a blocked successor keeps its beat
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld[FST] && !rdy[FST+1] |=> vld[FST])
      else $error("stalled Horner stage dropped its beat");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_erf_value <= OUT_MAX) && (rsp_erf_value >= -OUT_MAX))
      else $error("result magnitude above one");
`endif

endmodule
